FILE: design/patch_unpack_scatter_defines.svh
// ----------------------------------------------------------------------------
// patch_unpack_scatter_defines
// Assertion macros shared by the patch unpack scatter block. In synthesis the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef PATCH_UNPACK_SCATTER_DEFINES_SVH
`define PATCH_UNPACK_SCATTER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define PSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Checked at every clock edge, reset included.
`define PSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define PSU_ASSERT(lbl, prop, msg)
`define PSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Types, constants and helpers shared by the patch unpack scatter block.
// ----------------------------------------------------------------------------
package psu_pkg;

  // Payload widths.
  localparam int WORD_W = 32;
  localparam int ADDR_W = 30;

  // Configuration register widths and port shape.
  localparam int LAYOUT_W   = 1;
  localparam int PATCH_W    = 5;
  localparam int GRID_W     = 9;
  localparam int CHANNEL_W  = 7;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 3;

  // Default limits for the top-level parameters.
  localparam int DEF_MAX_PATCH    = 16;
  localparam int DEF_MAX_GRID     = 256;
  localparam int DEF_MAX_CHANNELS = 64;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYOUT_CHANNEL_MAJOR = 3'd0,
    CFG_PATCH_SIZE           = 3'd1,
    CFG_GRID_ROWS            = 3'd2,
    CFG_GRID_COLS            = 3'd3,
    CFG_CHANNELS_TOTAL       = 3'd4,
    CFG_CHANNELS_KEPT        = 3'd5
  } cfg_idx_e;

  // Configuration register file contents.
  typedef struct packed {
    logic [LAYOUT_W-1:0]  layout_channel_major;
    logic [PATCH_W-1:0]   patch_size;
    logic [GRID_W-1:0]    grid_rows;
    logic [GRID_W-1:0]    grid_cols;
    logic [CHANNEL_W-1:0] channels_total;
    logic [CHANNEL_W-1:0] channels_kept;
  } cfg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_ACC,
    ST_SUM,
    ST_OUT
  } psu_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // request accepted: capture word, advance counters
    logic prod;   // form the area and row-offset products
    logic acc;    // form the plane offset and the in-plane offset
    logic sum;    // add up the address and load the output register
  } cmd_t;

  // Saturate a register value into 1..hi.
  function automatic logic [31:0] clamp_range(logic [31:0] v, logic [31:0] hi);
    logic [31:0] r;
    r = v;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

FILE: design/psu_in_if.sv
// ----------------------------------------------------------------------------
// psu_in_if
// Input channel: one token-matrix word per request.
// ----------------------------------------------------------------------------
interface psu_in_if import psu_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_in;

  modport source (output valid, output word_in, input ready);
  modport sink   (input valid, input word_in, output ready);

endinterface

FILE: design/psu_out_if.sv
// ----------------------------------------------------------------------------
// psu_out_if
// Output channel: the word with its image address and flags.
// ----------------------------------------------------------------------------
interface psu_out_if import psu_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_out;
  logic [ADDR_W-1:0] dest_address;
  logic              keep;
  logic              last;

  modport source (output valid, output word_out, output dest_address, output keep,
                  output last, input ready);
  modport sink   (input valid, input word_out, input dest_address, input keep,
                  input last, output ready);

endinterface

FILE: design/psu_cfg.sv
// ----------------------------------------------------------------------------
// psu_cfg
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module psu_cfg import psu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write into the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LAYOUT_CHANNEL_MAJOR: cfg_d.layout_channel_major = cfg_data_i[LAYOUT_W-1:0];
        CFG_PATCH_SIZE:           cfg_d.patch_size           = cfg_data_i[PATCH_W-1:0];
        CFG_GRID_ROWS:            cfg_d.grid_rows            = cfg_data_i[GRID_W-1:0];
        CFG_GRID_COLS:            cfg_d.grid_cols            = cfg_data_i[GRID_W-1:0];
        CFG_CHANNELS_TOTAL:       cfg_d.channels_total       = cfg_data_i[CHANNEL_W-1:0];
        CFG_CHANNELS_KEPT:        cfg_d.channels_kept        = cfg_data_i[CHANNEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layout_channel_major <= LAYOUT_W'(0);
      cfg_q.patch_size           <= PATCH_W'(2);
      cfg_q.grid_rows            <= GRID_W'(1);
      cfg_q.grid_cols            <= GRID_W'(1);
      cfg_q.channels_total       <= CHANNEL_W'(1);
      cfg_q.channels_kept        <= CHANNEL_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/psu_dp.sv
// ----------------------------------------------------------------------------
// psu_dp
// Datapath: position counters, address arithmetic over three registered
// steps, and the output register.
// ----------------------------------------------------------------------------
module psu_dp import psu_pkg::*; #(
  parameter int MAX_PATCH    = DEF_MAX_PATCH,
  parameter int MAX_GRID     = DEF_MAX_GRID,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  input  logic [WORD_W-1:0] in_word_i,
  output logic [WORD_W-1:0] out_word_o,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic              out_keep_o,
  output logic              out_last_o
);

  // Widths of the clamped limits and of the counters.
  localparam int PVW   = $clog2(MAX_PATCH + 1);
  localparam int GVW   = $clog2(MAX_GRID + 1);
  localparam int CVW   = $clog2(MAX_CHANNELS + 1);
  localparam int PCW   = (MAX_PATCH > 1) ? $clog2(MAX_PATCH) : 1;
  localparam int GCW   = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int CCW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DIM_W = PVW + GVW;
  localparam int PROD_W = 2 * DIM_W;

  // Clamped limits.
  logic [PVW-1:0] p;
  logic [GVW-1:0] hp, wp;
  logic [CVW-1:0] ct;

  // Position counters.
  logic [GCW-1:0] row_q, row_d, col_q, col_d;
  logic [CCW-1:0] ch_q, ch_d;
  logic [PCW-1:0] py_q, py_d, px_q, px_d;

  logic row_wrap, col_wrap, ch_wrap, py_wrap, px_wrap;
  logic ch_adv, py_adv, px_adv, col_adv, row_adv, token_done;

  // Captured request and address steps.
  logic [WORD_W-1:0] word_q;
  logic              keep_q, last_q;
  logic [CCW-1:0]    ch_s_q;
  logic [DIM_W-1:0]  h_q, w_q, y_q, x_q;
  logic [ADDR_W-1:0] hw_q, yw_q, chw_q, inplane_q;

  // Output register.
  logic [WORD_W-1:0] out_word_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_keep_q, out_last_q;

  assign p  = PVW'(clamp_range(32'(cfg_i.patch_size), 32'(MAX_PATCH)));
  assign hp = GVW'(clamp_range(32'(cfg_i.grid_rows), 32'(MAX_GRID)));
  assign wp = GVW'(clamp_range(32'(cfg_i.grid_cols), 32'(MAX_GRID)));
  assign ct = CVW'(clamp_range(32'(cfg_i.channels_total), 32'(MAX_CHANNELS)));

  // A counter wraps when its next value would reach its limit.
  assign px_wrap  = (32'(px_q) + 32'd1) >= 32'(p);
  assign py_wrap  = (32'(py_q) + 32'd1) >= 32'(p);
  assign ch_wrap  = (32'(ch_q) + 32'd1) >= 32'(ct);
  assign col_wrap = (32'(col_q) + 32'd1) >= 32'(wp);
  assign row_wrap = (32'(row_q) + 32'd1) >= 32'(hp);

  // Carry chain; the layout register picks which counter runs fastest.
  always_comb begin
    if (cfg_i.layout_channel_major == 1'b1) begin
      px_adv     = 1'b1;
      py_adv     = px_wrap;
      ch_adv     = px_wrap && py_wrap;
      token_done = px_wrap && py_wrap && ch_wrap;
    end else begin
      ch_adv     = 1'b1;
      px_adv     = ch_wrap;
      py_adv     = ch_wrap && px_wrap;
      token_done = ch_wrap && px_wrap && py_wrap;
    end
    col_adv = token_done;
    row_adv = token_done && col_wrap;

    px_d  = px_adv  ? (px_wrap  ? '0 : px_q  + PCW'(1)) : px_q;
    py_d  = py_adv  ? (py_wrap  ? '0 : py_q  + PCW'(1)) : py_q;
    ch_d  = ch_adv  ? (ch_wrap  ? '0 : ch_q  + CCW'(1)) : ch_q;
    col_d = col_adv ? (col_wrap ? '0 : col_q + GCW'(1)) : col_q;
    row_d = row_adv ? (row_wrap ? '0 : row_q + GCW'(1)) : row_q;
  end

  // Counters advance once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      ch_q  <= '0;
      py_q  <= '0;
      px_q  <= '0;
    end else if (cmd_i.load) begin
      row_q <= row_d;
      col_q <= col_d;
      ch_q  <= ch_d;
      py_q  <= py_d;
      px_q  <= px_d;
    end
  end

  // Capture the word and the image dimensions and coordinates.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= in_word_i;
      keep_q <= 32'(ch_q) < 32'(cfg_i.channels_kept);
      last_q <= row_adv && row_wrap;
      ch_s_q <= ch_q;
      h_q    <= DIM_W'(hp) * DIM_W'(p);
      w_q    <= DIM_W'(wp) * DIM_W'(p);
      y_q    <= DIM_W'(row_q) * DIM_W'(p) + DIM_W'(py_q);
      x_q    <= DIM_W'(col_q) * DIM_W'(p) + DIM_W'(px_q);
    end
  end

  // Plane area and row offset; products wrap at the address width.
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      hw_q <= ADDR_W'(PROD_W'(h_q) * PROD_W'(w_q));
      yw_q <= ADDR_W'(PROD_W'(y_q) * PROD_W'(w_q));
    end
  end

  // Plane offset and in-plane offset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      chw_q     <= ADDR_W'(ch_s_q) * hw_q;
      inplane_q <= yw_q + ADDR_W'(x_q);
    end
  end

  // Output register, held until the result is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      out_word_q <= word_q;
      out_addr_q <= chw_q + inplane_q;
      out_keep_q <= keep_q;
      out_last_q <= last_q;
    end
  end

  assign out_word_o = out_word_q;
  assign out_addr_o = out_addr_q;
  assign out_keep_o = out_keep_q;
  assign out_last_o = out_last_q;

endmodule

FILE: design/psu_ctrl.sv
// ----------------------------------------------------------------------------
// psu_ctrl
// Controller: sequences one request through the address steps and holds the
// result until it is taken.
// ----------------------------------------------------------------------------
`include "patch_unpack_scatter_defines.svh"

module psu_ctrl import psu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  psu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: state_d = ST_ACC;
      ST_ACC:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = in_valid_i ? ST_PROD : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and datapath commands. A new request is taken in the cycle
  // the held result leaves.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_PROD: cmd_o.prod = 1'b1;
      ST_ACC:  cmd_o.acc  = 1'b1;
      ST_SUM:  cmd_o.sum  = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
      end
      default: ;
    endcase
    cmd_o.load = in_valid_i && in_ready_o;
  end

  `PSU_ASSERT(a_cmd_onehot, $onehot0({cmd_o.load, cmd_o.prod, cmd_o.acc, cmd_o.sum}), "psu_ctrl: overlapping datapath commands")
  `PSU_ASSERT(a_load_then_prod, cmd_o.load |=> cmd_o.prod, "psu_ctrl: captured request not multiplied next cycle")
  `PSU_ASSERT(a_sum_then_out, cmd_o.sum |=> out_valid_o, "psu_ctrl: output register loaded but not presented")
  `PSU_ASSERT(a_out_not_busy, out_valid_o |-> !cmd_o.prod && !cmd_o.acc && !cmd_o.sum, "psu_ctrl: output register changing while presented")
  `PSU_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && !cmd_o.sum, "psu_ctrl: activity during reset")

endmodule

FILE: design/patch_unpack_scatter.sv
// A result is valid after its request has passed, in turn, the four registered
// steps (capture, products, offsets, sum); one request holds them all, so the
// block takes no new request while a result is in flight or held.
// A new request is taken in the same cycle the previous result is taken.
// Reset (rst_ni low, asynchronous) clears the controller, the position
// counters and the configuration registers to their default values.
// ----------------------------------------------------------------------------
// patch_unpack_scatter
// Scatters token-matrix words into a channel-planar image: each word leaves
// with its image address, a keep flag for the leading channels and a last
// flag on the final word of the matrix.
// ----------------------------------------------------------------------------
module patch_unpack_scatter import psu_pkg::*; #(
  parameter int MAX_PATCH    = DEF_MAX_PATCH,
  parameter int MAX_GRID     = DEF_MAX_GRID,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  psu_in_if.sink                in_i,
  psu_out_if.source             out_o
);

  cfg_t cfg;
  cmd_t cmd;

  // Configuration registers.
  psu_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Sequencing and handshake.
  psu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Counters and address arithmetic.
  psu_dp #(
    .MAX_PATCH    (MAX_PATCH),
    .MAX_GRID     (MAX_GRID),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .in_word_i  (in_i.word_in),
    .out_word_o (out_o.word_out),
    .out_addr_o (out_o.dest_address),
    .out_keep_o (out_o.keep),
    .out_last_o (out_o.last)
  );

endmodule

FILE: tb/sv/patch_unpack_scatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_unpack_scatter_tb
// Self-checking bench for the patch unpack scatter block. A table of
// directed requests covers reset defaults, register extremes, out-of-range
// settings and mid-stream reconfiguration. Random settings and random words
// follow, with random gaps on the request side and random stalls on the
// result side. Results are checked against the plan or a position tracker.
// ----------------------------------------------------------------------------
module patch_unpack_scatter_tb;
  import psu_pkg::*;

  localparam int MAX_PATCH      = DEF_MAX_PATCH;
  localparam int MAX_GRID       = DEF_MAX_GRID;
  localparam int MAX_CHANNELS   = DEF_MAX_CHANNELS;
  localparam int RANDOM_WORDS   = 2000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SHOWN_ERRORS   = 10;
  localparam int PLAN_ROWS      = 26;

  // Indexes beyond the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  // One scattered word as it leaves the block.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [ADDR_W-1:0] addr;
    logic              keep;
    logic              last;
  } scatter_t;

  // One row of the directed plan: an optional register write, then an
  // optional request with an optional hand-written result.
  typedef struct packed {
    logic                  cfg_en;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  item_en;
    logic [WORD_W-1:0]     word;
    logic                  typed;
    logic [ADDR_W-1:0]     addr;
    logic                  keep;
    logic                  last;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Reset settings: 2x2 patch, one token, one channel.
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'h0000_0000, 1'b1, 30'd0, 1'b1, 1'b0},
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'hFFFF_FFFF, 1'b1, 30'd1, 1'b1, 1'b0},
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'hA5A5_A5A5, 1'b1, 30'd2, 1'b1, 1'b0},
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'h5A5A_5A5A, 1'b1, 30'd3, 1'b1, 1'b1},
    // A kept count of zero discards everything.
    '{1'b1, CFG_CHANNELS_KEPT,        9'd0,   1'b1, 32'h0000_0001, 1'b1, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_CHANNELS_KEPT,        9'd1,   1'b1, 32'h8000_0000, 1'b1, 30'd1, 1'b1, 1'b0},
    // Zero sizes saturate to one, mid-matrix.
    '{1'b1, CFG_PATCH_SIZE,           9'd0,   1'b0, 32'h0,         1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_GRID_ROWS,            9'd0,   1'b0, 32'h0,         1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_GRID_COLS,            9'd0,   1'b0, 32'h0,         1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_CHANNELS_TOTAL,       9'd0,   1'b1, 32'h7FFF_FFFF, 1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'h1234_5678, 1'b1, 30'd0, 1'b1, 1'b1},
    '{1'b1, CFG_SPARE_A,              9'h1FF, 1'b1, 32'h0F0F_0F0F, 1'b1, 30'd0, 1'b1, 1'b1},
    // Oversized values saturate to the maximum; kept above total.
    '{1'b1, CFG_PATCH_SIZE,           9'd31,  1'b0, 32'h0,         1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_GRID_ROWS,            9'd511, 1'b0, 32'h0,         1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_GRID_COLS,            9'd511, 1'b0, 32'h0,         1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_CHANNELS_TOTAL,       9'd127, 1'b0, 32'h0,         1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_CHANNELS_KEPT,        9'd127, 1'b0, 32'h0,         1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_LAYOUT_CHANNEL_MAJOR, 9'd1,   1'b1, 32'hDEAD_BEEF, 1'b1, 30'd0, 1'b1, 1'b0},
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'hC3C3_C3C3, 1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'h3C3C_3C3C, 1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'h00FF_00FF, 1'b0, 30'd0, 1'b0, 1'b0},
    // Shrink the patch below the current sub-column, then swap the layout.
    '{1'b1, CFG_PATCH_SIZE,           9'd3,   1'b1, 32'hFF00_FF00, 1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'h1357_9BDF, 1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'h2468_ACE0, 1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b0, CFG_LAYOUT_CHANNEL_MAJOR, 9'd0,   1'b1, 32'hFEDC_BA98, 1'b0, 30'd0, 1'b0, 1'b0},
    '{1'b1, CFG_SPARE_B,              9'd0,   1'b1, 32'h0123_4567, 1'b0, 30'd0, 1'b0, 1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  psu_in_if  in_ch ();
  psu_out_if out_ch ();

  patch_unpack_scatter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Shadow register file and position counters, both at their reset values.
  cfg_t shadow_cfg = '{1'b0, 5'd2, 9'd1, 9'd1, 7'd1, 7'd1};
  int   tok_row = 0;
  int   tok_col = 0;
  int   chan    = 0;
  int   sub_row = 0;
  int   sub_col = 0;

  scatter_t pending_scatter[$];

  int  failures        = 0;
  int  words_sent      = 0;
  int  results_checked = 0;
  int  matrix_ends     = 0;
  int  settings_used   = 0;
  int  idle_cycles     = 0;
  bit  tx_steady       = 1'b0;
  bit  rx_steady       = 1'b0;

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Saturate a register value into 1..hi.
  function automatic int sat_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Step a position counter modulo lim; returns 1 when it wrapped to zero.
  function automatic bit bump(inout int cnt, input int lim);
    if (cnt + 1 >= lim) begin
      cnt = 0;
      return 1'b1;
    end
    cnt = cnt + 1;
    return 1'b0;
  endfunction

  // Words in one full matrix under the current settings.
  function automatic int matrix_words();
    int p;
    p = sat_dim(int'(shadow_cfg.patch_size), MAX_PATCH);
    return p * p * sat_dim(int'(shadow_cfg.grid_rows), MAX_GRID)
               * sat_dim(int'(shadow_cfg.grid_cols), MAX_GRID)
               * sat_dim(int'(shadow_cfg.channels_total), MAX_CHANNELS);
  endfunction

  // Image address and flags of the next word, then advance the position.
  function automatic scatter_t predict_scatter(logic [WORD_W-1:0] word);
    int               p;
    int               hp;
    int               wp;
    int               ct;
    longint unsigned  h;
    longint unsigned  w;
    longint unsigned  addr;
    bit               token_done;
    scatter_t         res;
    p  = sat_dim(int'(shadow_cfg.patch_size), MAX_PATCH);
    hp = sat_dim(int'(shadow_cfg.grid_rows), MAX_GRID);
    wp = sat_dim(int'(shadow_cfg.grid_cols), MAX_GRID);
    ct = sat_dim(int'(shadow_cfg.channels_total), MAX_CHANNELS);
    h  = longint'(hp * p);
    w  = longint'(wp * p);
    addr = longint'(chan) * h * w + longint'(tok_row * p + sub_row) * w
         + longint'(tok_col * p + sub_col);
    res.word = word;
    res.addr = addr[ADDR_W-1:0];
    res.keep = (chan < int'(shadow_cfg.channels_kept));
    res.last = 1'b0;
    token_done = 1'b0;
    // Channel-major: sub-column fastest, then sub-row, then channel.
    if (shadow_cfg.layout_channel_major) begin
      if (bump(sub_col, p)) begin
        if (bump(sub_row, p)) begin
          token_done = bump(chan, ct);
        end
      end
    end else begin
      if (bump(chan, ct)) begin
        if (bump(sub_col, p)) begin
          token_done = bump(sub_row, p);
        end
      end
    end
    if (token_done) begin
      if (bump(tok_col, wp)) begin
        res.last = bump(tok_row, hp);
      end
    end
    return res;
  endfunction

  // Gap before a request: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Register value near a limit, at the extremes of the port, or anywhere.
  function automatic int wide_value(int lim);
    case ($urandom_range(0, 4))
      0: return 0;
      1: return lim;
      2: return lim + 1;
      3: return (1 << CFG_DATA_W) - 1;
      default: return $urandom_range(0, (1 << CFG_DATA_W) - 1);
    endcase
  endfunction

  // Write one register and mirror it in the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LAYOUT_CHANNEL_MAJOR: shadow_cfg.layout_channel_major = data[LAYOUT_W-1:0];
      CFG_PATCH_SIZE:           shadow_cfg.patch_size           = data[PATCH_W-1:0];
      CFG_GRID_ROWS:            shadow_cfg.grid_rows            = data[GRID_W-1:0];
      CFG_GRID_COLS:            shadow_cfg.grid_cols            = data[GRID_W-1:0];
      CFG_CHANNELS_TOTAL:       shadow_cfg.channels_total       = data[CHANNEL_W-1:0];
      CFG_CHANNELS_KEPT:        shadow_cfg.channels_kept        = data[CHANNEL_W-1:0];
      default: ;
    endcase
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_scatter.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Offer one request and record its result once the block takes it.
  task automatic send_word(input logic [WORD_W-1:0] word, input int gap,
                           input bit use_typed, input scatter_t typed_res);
    scatter_t res;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.word_in <= word;
    do @(posedge clk_i); while (!in_ch.ready);
    res = predict_scatter(word);
    pending_scatter.push_back(use_typed ? typed_res : res);
    words_sent++;
  endtask

  task automatic note_failure(input string what, input scatter_t want, input scatter_t got);
    failures++;
    if (failures <= SHOWN_ERRORS) begin
      $display("[%0t] %s: expected word %h addr %h keep %b last %b, got word %h addr %h keep %b last %b",
               $realtime, what, want.word, want.addr, want.keep, want.last,
               got.word, got.addr, got.keep, got.last);
    end
  endtask

  // Result side: random stalls, with stretches of none.
  initial begin
    int stall_left;
    int r;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && !rx_steady) begin
        r = $urandom_range(0, 99);
        if (r >= 95) stall_left = $urandom_range(8, 30);
        else if (r >= 75) stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest one due.
  always @(posedge clk_i) begin
    scatter_t got;
    scatter_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.word_out, out_ch.dest_address, out_ch.keep, out_ch.last};
      results_checked++;
      if (got.last) matrix_ends++;
      if (pending_scatter.size() == 0) begin
        note_failure("result with none due", '0, got);
      end else begin
        want = pending_scatter.pop_front();
        if (got.word !== want.word || got.addr !== want.addr ||
            got.keep !== want.keep || got.last !== want.last) begin
          note_failure("result mismatch", want, got);
        end
      end
    end
  end

  // Stop the run if no request and no result moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("patch_unpack_scatter: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus.
  initial begin
    int random_sent;
    int count;
    int p_tmp;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_LAYOUT_CHANNEL_MAJOR;
    cfg_data_i    = '0;
    in_ch.valid   = 1'b0;
    in_ch.word_in = '0;
    random_sent   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan.
    for (int n = 0; n < PLAN_ROWS; n++) begin
      if (PLAN[n].cfg_en) begin
        drain();
        write_reg(PLAN[n].idx, int'(PLAN[n].val));
        cfg_we_i <= 1'b0;
        settings_used++;
      end
      if (PLAN[n].item_en) begin
        send_word(PLAN[n].word, pick_gap(), PLAN[n].typed,
                  '{PLAN[n].word, PLAN[n].addr, PLAN[n].keep, PLAN[n].last});
      end
    end

    // Random settings, each followed by a burst of random words.
    while (random_sent < RANDOM_WORDS) begin
      drain();
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        // Anything the port can carry, extremes weighted.
        if ($urandom_range(0, 1)) write_reg(CFG_LAYOUT_CHANNEL_MAJOR, wide_value(1));
        if ($urandom_range(0, 1)) write_reg(CFG_PATCH_SIZE, wide_value(MAX_PATCH));
        if ($urandom_range(0, 1)) write_reg(CFG_GRID_ROWS, wide_value(MAX_GRID));
        if ($urandom_range(0, 1)) write_reg(CFG_GRID_COLS, wide_value(MAX_GRID));
        if ($urandom_range(0, 1)) write_reg(CFG_CHANNELS_TOTAL, wide_value(MAX_CHANNELS));
        write_reg(CFG_CHANNELS_KEPT, wide_value(MAX_CHANNELS));
        count = $urandom_range(40, 150);
      end else begin
        // Small matrices, so that their last words come around often.
        if ($urandom_range(0, 3) != 0) write_reg(CFG_LAYOUT_CHANNEL_MAJOR, $urandom_range(0, 1));
        p_tmp = $urandom_range(1, 4);
        write_reg(CFG_PATCH_SIZE, p_tmp);
        write_reg(CFG_GRID_ROWS, $urandom_range(1, 3));
        write_reg(CFG_GRID_COLS, $urandom_range(1, 3));
        write_reg(CFG_CHANNELS_TOTAL, $urandom_range(1, 4));
        write_reg(CFG_CHANNELS_KEPT, $urandom_range(0, int'(shadow_cfg.channels_total) + 1));
        count = matrix_words() * $urandom_range(1, 2) + $urandom_range(0, 2);
        if (count > 300) count = 300;
      end
      if ($urandom_range(0, 15) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom_range(0, 511));
      end
      cfg_we_i <= 1'b0;
      settings_used++;
      // Short bursts leave the position mid-matrix for the next setting.
      if ($urandom_range(0, 5) == 0) count = $urandom_range(1, 6);
      for (int k = 0; k < count; k++) begin
        send_word($urandom, pick_gap(), 1'b0, '0);
        random_sent++;
      end
    end

    // Wind down and report.
    in_ch.valid <= 1'b0;
    while (pending_scatter.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_scatter.size() != 0) failures++;
    $display("Run covered %0d words under %0d register settings.", words_sent, settings_used);
    $display("Checked %0d results, %0d matrix ends, %0d failures.",
             results_checked, matrix_ends, failures);
    if (failures == 0) begin
      $display("patch_unpack_scatter: match");
    end else begin
      $display("patch_unpack_scatter: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/psu_pkg.sv
design/psu_in_if.sv
design/psu_out_if.sv
design/psu_cfg.sv
design/psu_dp.sv
design/psu_ctrl.sv
design/patch_unpack_scatter.sv
tb/sv/patch_unpack_scatter_tb.sv
